[rtl/core/gvs_pkg.sv]
// Shared constants, configuration register codes and controller/datapath types.
package gvs_pkg;

    localparam int MAX_COLS   = 32;
    localparam int MAX_ROWS   = 64;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int VEL_W      = 16;
    localparam int CURL_W     = 24;
    localparam int INV_W      = 16;
    localparam int COLS_CFG_W = 6;
    localparam int ROWS_CFG_W = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LINE_DEPTH = 3 * MAX_COLS;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_COLS   = 3'd0,
        CFG_ROWS   = 3'd1,
        CFG_WRAP   = 3'd2,
        CFG_INV_DX = 3'd3,
        CFG_INV_DY = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic take_in;
        logic rd0;
        logic rd1;
        logic rd2;
        logic mul;
        logic load_out;
        logic next_target;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic acc_go;
        logic out_free;
        logic more;
    } t_dp_sts;

endpackage

[rtl/core/gvs_in_if.sv]
// Input channel carrying one velocity cell per word.
interface gvs_in_if;
    import gvs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;

    modport source (output valid, output vel_x, output vel_y, input ready);
    modport sink (input valid, input vel_x, input vel_y, output ready);
endinterface

[rtl/core/gvs_out_if.sv]
// Output channel carrying one vorticity result per word.
interface gvs_out_if;
    import gvs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CURL_W-1:0] curl_value;
    logic [COL_W-1:0]         out_col;
    logic [ROW_W-1:0]         out_row;
    logic                     run_last;
    logic                     frame_done;

    modport source (output valid, output curl_value, output out_col, output out_row,
                    output run_last, output frame_done, input ready);
    modport sink (input valid, input curl_value, input out_col, input out_row,
                  input run_last, input frame_done, output ready);
endinterface

[rtl/core/gvs_cfg_if.sv]
// Configuration write channel carrying a register index and write data.
interface gvs_cfg_if;
    import gvs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

[rtl/core/gvs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/gvs_ctrl.sv]
// Sequencing state machine for line buffer reads, arithmetic and result hand-off.
module gvs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gvs_pkg::t_dp_sts i_sts,
    output gvs_pkg::t_dp_cmd o_cmd
);
    import gvs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD0  = 6'b000010,
        S_RD1  = 6'b000100,
        S_RD2  = 6'b001000,
        S_MUL  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.take_in = 1'b1;
                if (i_sts.in_valid && i_sts.acc_go) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                o_cmd.rd0 = 1'b1;
                n_state   = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_sts.more) begin
                        o_cmd.next_target = 1'b1;
                        n_state           = S_RD0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_result_after_five: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_sts.in_valid && i_sts.acc_go) |-> ##5 (r_state == S_OUT))
        else $error("result stage not reached five cycles after acceptance");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_sts.out_free) |=> (r_state == S_OUT))
        else $error("left the result stage while the output register was full");
endmodule

[rtl/core/gvs_dp.sv]
// Datapath: configuration registers, line buffers, raster counters and curl arithmetic.
module gvs_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gvs_in_if.sink           i_in,
    gvs_out_if.source        o_out,
    gvs_cfg_if.sink          i_cfg,
    input  gvs_pkg::t_dp_cmd i_cmd,
    output gvs_pkg::t_dp_sts o_sts
);
    import gvs_pkg::*;

    localparam int DIFF_W    = VEL_W + 1;
    localparam int PROD_W    = DIFF_W + INV_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_DROP = 9;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (FRAC_DROP - 1));
    localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'(2 ** (CURL_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN    = -(SUM_W'(2 ** (CURL_W - 1)));

    function automatic logic [1:0] slot_prev(input logic [1:0] s);
        logic [1:0] v;
        case (s)
            2'd0:    v = 2'd2;
            2'd1:    v = 2'd0;
            default: v = 2'd1;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] slot_next(input logic [1:0] s);
        logic [1:0] v;
        case (s)
            2'd0:    v = 2'd1;
            2'd1:    v = 2'd2;
            default: v = 2'd0;
        endcase
        return v;
    endfunction

    function automatic logic [LINE_AW-1:0] line_addr(input logic [1:0] s,
                                                     input logic [COL_W-1:0] col);
        return LINE_AW'(s * MAX_COLS + col);
    endfunction

    // Configuration.
    logic [COLS_CFG_W-1:0] r_cols_cfg;
    logic [ROWS_CFG_W-1:0] r_rows_cfg;
    logic                  r_wrap;
    logic [INV_W-1:0]      r_inv_dx;
    logic [INV_W-1:0]      r_inv_dy;

    // Raster position of the next input cell.
    logic [COL_W-1:0] r_col_count;
    logic [ROW_W-1:0] r_row_count;
    logic [1:0]       r_slot;

    // The accepted cell.
    logic [1:0]       r_item_slot;
    logic [ROW_W-1:0] r_item_row;
    logic             r_item_fend;

    // The result being worked on.
    logic [COL_W-1:0] r_t_col;
    logic [1:0]       r_t_uy_slot;
    logic [1:0]       r_t_uxp_slot;
    logic [1:0]       r_t_uxm_slot;
    logic             r_t_yone;
    logic [ROW_W-1:0] r_t_row;
    logic             r_t_flush;

    logic signed [VEL_W-1:0]  r_ux_p;
    logic signed [VEL_W-1:0]  r_uy_p;
    logic signed [DIFF_W-1:0] r_dxd;
    logic signed [DIFF_W-1:0] r_dyd;
    logic signed [PROD_W-1:0] r_tx;
    logic signed [PROD_W-1:0] r_ty;

    logic                     r_out_valid;
    logic signed [CURL_W-1:0] r_out_curl;
    logic [COL_W-1:0]         r_out_col;
    logic [ROW_W-1:0]         r_out_row;
    logic                     r_out_last;
    logic                     r_out_fdone;

    logic [COL_W-1:0]         w_cols_m1;
    logic [ROW_W-1:0]         w_rows_m1;
    logic                     w_row_end;
    logic                     w_frame_end;
    logic                     w_accept;
    logic                     w_lo_edge;
    logic                     w_hi_edge;
    logic [COL_W-1:0]         w_xm;
    logic [COL_W-1:0]         w_xp;
    logic                     w_x_one;
    logic                     w_flush_last;
    logic [1:0]               w_fl_slot;
    logic [ROW_W-1:0]         w_fl_row;
    logic [LINE_AW-1:0]       w_waddr;
    logic [LINE_AW-1:0]       w_ux_raddr;
    logic [LINE_AW-1:0]       w_uy_raddr;
    logic signed [VEL_W-1:0]  w_ux_rdata;
    logic signed [VEL_W-1:0]  w_uy_rdata;
    logic signed [PROD_W-1:0] w_mx_dy;
    logic signed [PROD_W-1:0] w_mx_dx;
    logic signed [PROD_W-1:0] w_mx_ix;
    logic signed [PROD_W-1:0] w_mx_iy;
    logic signed [SUM_W-1:0]  w_tx_e;
    logic signed [SUM_W-1:0]  w_ty_e;
    logic signed [SUM_W-1:0]  w_tx2;
    logic signed [SUM_W-1:0]  w_ty2;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  w_shift;
    logic signed [CURL_W-1:0] w_curl;

    // Sizes held to their legal ranges.
    always_comb begin
        if (r_cols_cfg < COLS_CFG_W'(2)) begin
            w_cols_m1 = COL_W'(1);
        end else if (r_cols_cfg > COLS_CFG_W'(MAX_COLS)) begin
            w_cols_m1 = COL_W'(MAX_COLS - 1);
        end else begin
            w_cols_m1 = COL_W'(r_cols_cfg - COLS_CFG_W'(1));
        end
        if (r_rows_cfg < ROWS_CFG_W'(2)) begin
            w_rows_m1 = ROW_W'(1);
        end else if (r_rows_cfg > ROWS_CFG_W'(MAX_ROWS)) begin
            w_rows_m1 = ROW_W'(MAX_ROWS - 1);
        end else begin
            w_rows_m1 = ROW_W'(r_rows_cfg - ROWS_CFG_W'(1));
        end
    end

    assign w_row_end   = r_col_count >= w_cols_m1;
    assign w_frame_end = w_row_end && (r_row_count >= w_rows_m1);
    assign w_accept    = i_in.valid && i_cmd.take_in;

    assign i_in.ready  = i_cmd.take_in;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= COLS_CFG_W'(MAX_COLS);
            r_rows_cfg <= ROWS_CFG_W'(MAX_ROWS);
            r_wrap     <= 1'b0;
            r_inv_dx   <= INV_W'(256);
            r_inv_dy   <= INV_W'(256);
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                CFG_COLS:   r_cols_cfg <= i_cfg.data[COLS_CFG_W-1:0];
                CFG_ROWS:   r_rows_cfg <= i_cfg.data[ROWS_CFG_W-1:0];
                CFG_WRAP:   r_wrap     <= i_cfg.data[0];
                CFG_INV_DX: r_inv_dx   <= i_cfg.data[INV_W-1:0];
                CFG_INV_DY: r_inv_dy   <= i_cfg.data[INV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_slot      <= 2'd0;
        end else if (w_accept) begin
            if (w_frame_end) begin
                r_col_count <= '0;
                r_row_count <= '0;
                r_slot      <= 2'd0;
            end else if (w_row_end) begin
                r_col_count <= '0;
                r_row_count <= r_row_count + ROW_W'(1);
                r_slot      <= slot_next(r_slot);
            end else begin
                r_col_count <= r_col_count + COL_W'(1);
            end
        end
    end

    // Neighbour columns of the result cell, with the edge rule.
    assign w_lo_edge    = r_t_col == '0;
    assign w_hi_edge    = r_t_col >= w_cols_m1;
    assign w_xm         = w_lo_edge ? (r_wrap ? w_cols_m1 : r_t_col) : r_t_col - COL_W'(1);
    assign w_xp         = w_hi_edge ? (r_wrap ? '0 : r_t_col) : r_t_col + COL_W'(1);
    assign w_x_one      = !r_wrap && (w_lo_edge || w_hi_edge);
    assign w_flush_last = r_t_col == w_cols_m1;

    assign w_fl_slot = w_accept ? r_slot : r_item_slot;
    assign w_fl_row  = w_accept ? r_row_count : r_item_row;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item_slot <= r_slot;
            r_item_row  <= r_row_count;
            r_item_fend <= w_frame_end;
        end
        if (w_accept && r_row_count != '0) begin
            r_t_col      <= r_col_count;
            r_t_uy_slot  <= slot_prev(r_slot);
            r_t_uxp_slot <= r_slot;
            r_t_uxm_slot <= (r_row_count == ROW_W'(1)) ? slot_prev(r_slot) : slot_next(r_slot);
            r_t_yone     <= r_row_count == ROW_W'(1);
            r_t_row      <= r_row_count - ROW_W'(1);
            r_t_flush    <= 1'b0;
        end else if (w_accept || (i_cmd.next_target && !r_t_flush)) begin
            r_t_col      <= '0;
            r_t_uy_slot  <= w_fl_slot;
            r_t_uxp_slot <= w_fl_slot;
            r_t_uxm_slot <= slot_prev(w_fl_slot);
            r_t_yone     <= 1'b1;
            r_t_row      <= w_fl_row;
            r_t_flush    <= 1'b1;
        end else if (i_cmd.next_target) begin
            r_t_col <= r_t_col + COL_W'(1);
        end
    end

    assign w_waddr    = line_addr(r_slot, r_col_count);
    assign w_ux_raddr = line_addr(i_cmd.rd0 ? r_t_uxp_slot : r_t_uxm_slot, r_t_col);
    assign w_uy_raddr = line_addr(r_t_uy_slot, i_cmd.rd0 ? w_xp : w_xm);

    gvs_ram #(
        .WIDTH (VEL_W),
        .DEPTH (LINE_DEPTH)
    ) u_ux_lines (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_waddr),
        .i_wdata (i_in.vel_x),
        .i_raddr (w_ux_raddr),
        .o_rdata (w_ux_rdata)
    );

    gvs_ram #(
        .WIDTH (VEL_W),
        .DEPTH (LINE_DEPTH)
    ) u_uy_lines (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_waddr),
        .i_wdata (i_in.vel_y),
        .i_raddr (w_uy_raddr),
        .o_rdata (w_uy_rdata)
    );

    assign w_mx_dy = PROD_W'(r_dyd);
    assign w_mx_dx = PROD_W'(r_dxd);
    assign w_mx_ix = PROD_W'($signed({1'b0, r_inv_dx}));
    assign w_mx_iy = PROD_W'($signed({1'b0, r_inv_dy}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd1) begin
            r_ux_p <= w_ux_rdata;
            r_uy_p <= w_uy_rdata;
        end
        if (i_cmd.rd2) begin
            r_dxd <= DIFF_W'(r_ux_p) - DIFF_W'(w_ux_rdata);
            r_dyd <= DIFF_W'(r_uy_p) - DIFF_W'(w_uy_rdata);
        end
        if (i_cmd.mul) begin
            r_tx <= w_mx_dy * w_mx_ix;
            r_ty <= w_mx_dx * w_mx_iy;
        end
    end

    // One-sided differences are doubled; round half up and drop to Q12.12.
    assign w_tx_e  = SUM_W'(r_tx);
    assign w_ty_e  = SUM_W'(r_ty);
    assign w_tx2   = w_x_one ? (w_tx_e <<< 1) : w_tx_e;
    assign w_ty2   = r_t_yone ? (w_ty_e <<< 1) : w_ty_e;
    assign w_sum   = w_tx2 - w_ty2 + ROUND_HALF;
    assign w_shift = w_sum >>> FRAC_DROP;

    always_comb begin
        if (w_shift > SAT_MAX) begin
            w_curl = CURL_W'(SAT_MAX);
        end else if (w_shift < SAT_MIN) begin
            w_curl = CURL_W'(SAT_MIN);
        end else begin
            w_curl = CURL_W'(w_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_curl  <= w_curl;
            r_out_col   <= r_t_col;
            r_out_row   <= r_t_row;
            r_out_last  <= r_t_flush ? w_flush_last : !r_item_fend;
            r_out_fdone <= r_t_flush && w_flush_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.curl_value = r_out_curl;
    assign o_out.out_col    = r_out_col;
    assign o_out.out_row    = r_out_row;
    assign o_out.run_last   = r_out_last;
    assign o_out.frame_done = r_out_fdone;

    assign o_sts.in_valid = i_in.valid;
    assign o_sts.acc_go   = (r_row_count != '0) || w_frame_end;
    assign o_sts.out_free = !r_out_valid || o_out.ready;
    assign o_sts.more     = r_t_flush ? !w_flush_last : r_item_fend;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_row_count != '0) |=> !i_in.ready)
        else $error("input still taken while a result is being worked on");

    a_frame_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && r_t_flush && w_flush_last) |=> (r_out_valid && r_out_fdone))
        else $error("last flush result not marked as end of frame");

    a_slot_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row_count == '0) |-> (r_slot == 2'd0))
        else $error("line buffer slot out of step with the row count");
endmodule

[rtl/core/grid_vorticity_stencil_core.sv]
// Top level of the streaming 2D vorticity stencil.
// A cell of the first row is taken while the controller stays idle and gives no result.
// Any other cell goes through the states RD0, RD1, RD2, MUL and OUT before its result is in the
// output register and the next cell is taken: two line buffer reads, a subtract, a multiply,
// round and load. The last cell adds one result per column; a full output register stalls.
// Reset clears the counters and sets the registers to their defaults; line buffers are not cleared.
module grid_vorticity_stencil_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gvs_in_if.sink    i_in,
    gvs_out_if.source o_out,
    gvs_cfg_if.sink   i_cfg
);
    import gvs_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    gvs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    gvs_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );
endmodule
